// ----- design/lsw_pkg.sv -----
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types, codes and helpers for the lap stopwatch.
// ----------------------------------------------------------------------------
package lsw_pkg;

  localparam int MAX_LAPS = 16;
  localparam int CNT_W    = $clog2(MAX_LAPS + 1);
  localparam int IDX_W    = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;

  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_STOP  = 3'd2;
  localparam logic [2:0] FN_LAP   = 3'd3;
  localparam logic [2:0] FN_RESET = 3'd4;
  localparam logic [2:0] FN_READ  = 3'd5;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] lap_index;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] lap_ticks;
    logic [47:0] whole_ticks;
    logic [1:0]  run_state;
    logic [31:0] lap_value;
    logic        lap_valid;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic add;
  } cell_ctl_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

endpackage

// ----- design/lsw_cell.sv -----
// ----------------------------------------------------------------------------
// lsw_cell
// One lap record: accumulates the closed interval and shifts toward older laps.
// ----------------------------------------------------------------------------
module lsw_cell (
  input  logic              clk,
  input  lsw_pkg::cell_ctl_t ctl,
  input  logic [31:0]       addend,
  input  logic [31:0]       prev_i,
  output logic [31:0]       pass_o,
  output logic [31:0]       val_o
);

  logic [31:0] val_r;
  logic [31:0] val_nxt;
  logic [31:0] sum;

  always_comb begin
    sum     = ctl.add ? lsw_pkg::sat_add32(val_r, addend) : val_r;
    val_nxt = ctl.shift ? prev_i : sum;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift || ctl.add) begin
      val_r <= val_nxt;
    end
  end

  assign pass_o = sum;
  assign val_o  = val_r;

endmodule

// ----- design/lap_stopwatch.sv -----
// ----------------------------------------------------------------------------
// lap_stopwatch
// Stopwatch with saturating tick counters and a shift chain of lap records.
// ----------------------------------------------------------------------------
//  channel | ports                        | direction
//  in      | in_valid, in_stall, in_data  | command word in
//  out     | out_valid, out_stall, out_data | result word out
//
//  One word per cycle while in_stall is low: each command completes in the cycle it is taken.
//  The result sits in one output register; a new word is taken while the
//  previous result is taken in the same cycle or was already taken.
//  in_stall rises only while a result waits under out_stall.
//  Reset clears the run state, counters, lap count and output valid; lap cells need no reset.
// ----------------------------------------------------------------------------
module lap_stopwatch (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lsw_pkg::out_word_t out_data
);

  logic [1:0]                   mode_r,  mode_nxt;
  logic [47:0]                  total_r, total_nxt;
  logic [31:0]                  since_r, since_nxt;
  logic [lsw_pkg::CNT_W-1:0]    cnt_r,   cnt_nxt;
  logic                         out_valid_r;
  lsw_pkg::out_word_t           out_data_r;
  lsw_pkg::out_word_t           res;
  logic                         fire;
  logic                         push;
  logic                         close;
  logic [31:0]                  lap_val  [lsw_pkg::MAX_LAPS];
  logic [31:0]                  lap_pass [lsw_pkg::MAX_LAPS];
  logic [lsw_pkg::IDX_W-1:0]    rd_idx;
  logic [8:0]                   idx_ext;
  logic [8:0]                   cnt_ext;

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;
  assign rd_idx   = lsw_pkg::IDX_W'(in_data.lap_index);
  assign idx_ext  = {5'd0, in_data.lap_index};
  assign cnt_ext  = 9'(cnt_r);

  always_comb begin
    mode_nxt     = mode_r;
    total_nxt    = total_r;
    since_nxt    = since_r;
    cnt_nxt      = cnt_r;
    push         = 1'b0;
    close        = 1'b0;
    res          = '0;
    unique case (in_data.func)
      lsw_pkg::FN_TICK: begin
        res.accepted = 1'b1;
        if (mode_r == lsw_pkg::MODE_RUN && since_r != 32'hFFFF_FFFF) begin
          since_nxt = since_r + 32'd1;
        end
      end
      lsw_pkg::FN_START: begin
        if (mode_r == lsw_pkg::MODE_INIT) begin
          total_nxt = '0;
          cnt_nxt   = lsw_pkg::CNT_W'(1);
          push      = 1'b1;
        end
        if (mode_r != lsw_pkg::MODE_RUN) begin
          since_nxt    = '0;
          mode_nxt     = lsw_pkg::MODE_RUN;
          res.accepted = 1'b1;
        end
      end
      lsw_pkg::FN_STOP: begin
        if (mode_r == lsw_pkg::MODE_RUN) begin
          close        = 1'b1;
          total_nxt    = lsw_pkg::sat_add48(total_r, since_r);
          since_nxt    = '0;
          mode_nxt     = lsw_pkg::MODE_STOP;
          res.accepted = 1'b1;
        end
      end
      lsw_pkg::FN_LAP: begin
        if (mode_r == lsw_pkg::MODE_RUN) begin
          close         = 1'b1;
          push          = 1'b1;
          total_nxt     = lsw_pkg::sat_add48(total_r, since_r);
          res.lap_ticks = since_r;
          since_nxt     = '0;
          if (cnt_r != lsw_pkg::CNT_W'(lsw_pkg::MAX_LAPS)) begin
            cnt_nxt = cnt_r + lsw_pkg::CNT_W'(1);
          end
          res.accepted  = 1'b1;
        end
      end
      lsw_pkg::FN_RESET: begin
        mode_nxt     = lsw_pkg::MODE_INIT;
        total_nxt    = '0;
        since_nxt    = '0;
        cnt_nxt      = '0;
        res.accepted = 1'b1;
      end
      lsw_pkg::FN_READ: begin
        res.accepted = 1'b1;
        if (idx_ext < cnt_ext) begin
          res.lap_value = lap_val[rd_idx];
          res.lap_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.run_state = mode_nxt;
    if (mode_nxt == lsw_pkg::MODE_INIT) begin
      res.whole_ticks = '0;
    end else if (mode_nxt == lsw_pkg::MODE_RUN) begin
      res.whole_ticks = lsw_pkg::sat_add48(total_nxt, since_nxt);
    end else begin
      res.whole_ticks = total_nxt;
    end
  end

  for (genvar i = 0; i < lsw_pkg::MAX_LAPS; i++) begin : g_cell
    lsw_pkg::cell_ctl_t cctl;
    logic [31:0]        prev;
    assign cctl.shift = fire && push;
    if (i == 0) begin : g_head
      assign cctl.add = fire && close;
      assign prev     = '0;
    end else begin : g_body
      assign cctl.add = 1'b0;
      assign prev     = lap_pass[i-1];
    end
    lsw_cell u_cell (
      .clk    (clk),
      .ctl    (cctl),
      .addend (since_r),
      .prev_i (prev),
      .pass_o (lap_pass[i]),
      .val_o  (lap_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lsw_pkg::MODE_INIT;
      total_r     <= '0;
      since_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        mode_r      <= mode_nxt;
        total_r     <= total_nxt;
        since_r     <= since_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
